// ===== rtl/slcan_pkg.sv =====
// ----------------------------------------------------------------------------
// slcan_pkg
// Shared types, character codes and the hex digit decoder for the slcan
// ascii receive-command parser.
// ----------------------------------------------------------------------------
package slcan_pkg;

  // command letters and digit bounds
  localparam logic [7:0] CH_STD_DATA = 8'h74;  // 't'
  localparam logic [7:0] CH_STD_RTR  = 8'h72;  // 'r'
  localparam logic [7:0] CH_EXT_DATA = 8'h54;  // 'T'
  localparam logic [7:0] CH_EXT_RTR  = 8'h52;  // 'R'
  localparam logic [7:0] CH_ZERO     = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE     = 8'h39;  // '9'
  localparam logic [7:0] CH_EIGHT    = 8'h38;  // '8'
  localparam logic [7:0] CH_LA       = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF       = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA       = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF       = 8'h46;  // 'F'

  // line geometry
  localparam logic [4:0] POS_MAX     = 5'd31;
  localparam logic [4:0] STD_ID_LEN  = 5'd3;
  localparam logic [4:0] EXT_ID_LEN  = 5'd8;

  // output stream width: 100 payload bits padded to whole bytes
  localparam int OUT_BITS  = 32 + 4 + 64;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;
  localparam int OUT_TDATA_W = OUT_BYTES * 8;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [31:0] frame_id_word;
    logic [3:0]  length;
    logic [63:0] payload;
  } frame_t;

  // ascii hex digit to nibble, ok low for any other byte
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      h.ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
      h.ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
      h.ok = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

endpackage

// ===== rtl/slcan_parse.sv =====
// ----------------------------------------------------------------------------
// slcan_parse
// Per-character line state: command letter, identifier, length digit and
// data nibbles; flags a decoded frame on the end-of-line transaction.
// ----------------------------------------------------------------------------
module slcan_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           character,
  input  logic                 end_of_line,
  output logic                 res_valid,
  output slcan_pkg::frame_t    res_frame
);

  logic [4:0]  pos_r, pos_nxt;
  logic        ext_r, ext_nxt;
  logic        rtr_r, rtr_nxt;
  logic [31:0] id_r, id_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [63:0] data_r, data_nxt;
  logic        err_r, err_nxt;

  logic [4:0]     id_len;
  logic [4:0]     k;
  logic [3:0]     nib_idx;
  logic [4:0]     need;
  slcan_pkg::hex_t hex;

  assign id_len  = ext_r ? slcan_pkg::EXT_ID_LEN : slcan_pkg::STD_ID_LEN;
  assign hex     = slcan_pkg::hex_decode(character);
  assign k       = pos_r - id_len - 5'd2;
  // high nibble of each byte comes first
  assign nib_idx = {k[3:1], ~k[0]};
  assign need    = id_len + 5'd2 + (rtr_r ? 5'd0 : {len_r, 1'b0});

  // next line state
  always_comb begin
    pos_nxt  = pos_r;
    ext_nxt  = ext_r;
    rtr_nxt  = rtr_r;
    id_nxt   = id_r;
    len_nxt  = len_r;
    data_nxt = data_r;
    err_nxt  = err_r;
    if (fire) begin
      if (end_of_line) begin
        pos_nxt  = '0;
        ext_nxt  = 1'b0;
        rtr_nxt  = 1'b0;
        id_nxt   = '0;
        len_nxt  = '0;
        data_nxt = '0;
        err_nxt  = 1'b0;
      end else begin
        if (pos_r < slcan_pkg::POS_MAX) begin
          pos_nxt = pos_r + 5'd1;
        end
        if (!err_r) begin
          if (pos_r == 5'd0) begin
            case (character)
              slcan_pkg::CH_STD_DATA: begin
                ext_nxt = 1'b0;
                rtr_nxt = 1'b0;
              end
              slcan_pkg::CH_STD_RTR: begin
                ext_nxt = 1'b0;
                rtr_nxt = 1'b1;
              end
              slcan_pkg::CH_EXT_DATA: begin
                ext_nxt = 1'b1;
                rtr_nxt = 1'b0;
              end
              slcan_pkg::CH_EXT_RTR: begin
                ext_nxt = 1'b1;
                rtr_nxt = 1'b1;
              end
              default: err_nxt = 1'b1;
            endcase
          end else if (pos_r <= id_len) begin
            if (hex.ok) begin
              id_nxt = {id_r[27:0], hex.val};
            end else begin
              err_nxt = 1'b1;
            end
          end else if (pos_r == id_len + 5'd1) begin
            if (character >= slcan_pkg::CH_ZERO && character <= slcan_pkg::CH_EIGHT) begin
              len_nxt = character[3:0];
            end else begin
              err_nxt = 1'b1;
            end
          end else if (!rtr_r && k < {len_r, 1'b0}) begin
            if (hex.ok) begin
              for (int i = 0; i < 16; i++) begin
                if (nib_idx == 4'(i)) begin
                  data_nxt[i*4 +: 4] = data_r[i*4 +: 4] | hex.val;
                end
              end
            end else begin
              err_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ext_r  <= 1'b0;
      rtr_r  <= 1'b0;
      id_r   <= '0;
      len_r  <= '0;
      data_r <= '0;
      err_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      ext_r  <= ext_nxt;
      rtr_r  <= rtr_nxt;
      id_r   <= id_nxt;
      len_r  <= len_nxt;
      data_r <= data_nxt;
      err_r  <= err_nxt;
    end
  end

  // frame out on a well-formed end of line
  assign res_valid = fire && end_of_line && !err_r && (pos_r != 5'd0) && (pos_r >= need);
  assign res_frame.frame_id_word = id_r | {ext_r, rtr_r, 30'd0};
  assign res_frame.length        = len_r;
  assign res_frame.payload       = rtr_r ? 64'd0 : data_r;

  // any end of line starts a fresh line
  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && end_of_line |=> pos_r == 5'd0 && !err_r && data_r == 64'd0)
    else $error("line state not cleared after end of line");

  // an error can only be raised by a character already counted
  a_err_has_pos: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> pos_r != 5'd0)
    else $error("line error with empty line");

  // length digit never exceeds eight
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= 4'd8)
    else $error("length out of range");

endmodule

// ===== rtl/slcan_out_buf.sv =====
// ----------------------------------------------------------------------------
// slcan_out_buf
// Output register with a skid stage so the input side keeps flowing while a
// decoded frame waits for the consumer.
// ----------------------------------------------------------------------------
module slcan_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  slcan_pkg::frame_t  push_frame,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output slcan_pkg::frame_t  out_frame
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  slcan_pkg::frame_t out_frame_r, out_frame_nxt;
  slcan_pkg::frame_t skid_frame_r, skid_frame_nxt;
  logic              pop;

  assign pop = out_valid_r && out_ready;

  // move skid up, or load a new frame
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_frame_nxt  = out_frame_r;
    skid_valid_nxt = skid_valid_r;
    skid_frame_nxt = skid_frame_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_frame_nxt  = skid_frame_r;
        skid_valid_nxt = push;
        skid_frame_nxt = push_frame;
      end else begin
        out_valid_nxt = push;
        out_frame_nxt = push_frame;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_frame_nxt = push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_frame_r  <= out_frame_nxt;
    skid_frame_r <= skid_frame_nxt;
  end

  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;

  // skid only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a frame while output is empty");

  // no frame arrives while the skid is occupied
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("frame pushed into full buffer");

  // a taken output is refilled from the skid
  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> out_valid_r && out_frame_r == $past(skid_frame_r))
    else $error("skid frame lost");

endmodule

// ===== rtl/slcan_ascii_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// slcan_ascii_frame_parser_top
// Slcan ascii receive-command parser with stream interfaces.
// ----------------------------------------------------------------------------
// One ascii character per input transaction; in_tlast ends the command line
// and its character is ignored. Commands t/r (11-bit id, three hex digits)
// and T/R (29-bit id, eight hex digits) are followed by a length digit 0..8
// and, for data frames, two hex digits per byte, high nibble first. On a
// well-formed end of line one frame is registered into the output stage, or
// into its skid stage while that holds a frame; malformed or short lines
// give nothing. Characters flow while in_tready is high, and in_tready drops
// only while both the output register and its skid stage hold frames.
module slcan_ascii_frame_parser_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] character
  input  logic                               in_tlast,   // end_of_line
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] frame_id_word, [35:32] length, [99:36] payload, rest zero
  output logic [slcan_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic              fire;
  logic              res_valid;
  slcan_pkg::frame_t res_frame;
  slcan_pkg::frame_t out_frame;

  assign fire = in_tvalid && in_tready;

  slcan_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .character   (in_tdata),
    .end_of_line (in_tlast),
    .res_valid   (res_valid),
    .res_frame   (res_frame)
  );

  slcan_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_frame (res_frame),
    .space      (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_frame  (out_frame)
  );

  // pack fields, first field lowest
  assign out_tdata = {{(slcan_pkg::OUT_TDATA_W - slcan_pkg::OUT_BITS){1'b0}},
                      out_frame.payload, out_frame.length, out_frame.frame_id_word};

endmodule
